// ===== hdl/interface_name_validator_macros.svh =====
// ----------------------------------------------------------------------------
// Interface name validator: assertion macros
// Concurrent assertion shorthands shared by the validator RTL.
// ----------------------------------------------------------------------------
`ifndef INTERFACE_NAME_VALIDATOR_MACROS_SVH
`define INTERFACE_NAME_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define INV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("interface_name_validator: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define INV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("interface_name_validator: assertion failed");

`endif

// ===== hdl/inv_pkg.sv =====
// ----------------------------------------------------------------------------
// Interface name validator package
// Character codes, field widths and small helpers for the name parser.
// ----------------------------------------------------------------------------
`default_nettype none

package inv_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RUN_W   = 6;   // part lengths saturate at 63
  localparam int unsigned DLEN_W  = 5;
  localparam int unsigned UNIT_W  = 32;

  localparam logic [CHAR_W-1:0] CHAR_COLON      = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CHAR_DOT        = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'h39;

  localparam logic [RUN_W-1:0]  RUN_MAX  = 6'd63;
  localparam logic [DLEN_W-1:0] DLEN_MAX = 5'd31;
  localparam logic [UNIT_W-1:0] UNIT_MAX = 32'hFFFF_FFFE;

  typedef struct packed {
    logic [UNIT_W-1:0] acc;
    logic              ovf;
  } acc_step_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // acc * 10 + digit, clamped to all ones on overflow
  function automatic acc_step_t acc_step(input logic [UNIT_W-1:0] acc,
                                         input logic [3:0]        digit);
    logic [UNIT_W+3:0] wide;
    acc_step_t         res;
    wide    = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{UNIT_W{1'b0}}, digit};
    res.ovf = |wide[UNIT_W+3:UNIT_W];
    res.acc = res.ovf ? {UNIT_W{1'b1}} : wide[UNIT_W-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/inv_if.sv =====
// ----------------------------------------------------------------------------
// Interface name validator channels
// Valid/ready channels for name characters and for validation results.
// ----------------------------------------------------------------------------
`default_nettype none

interface inv_char_if;
  logic                          valid;
  logic                          ready;
  logic [inv_pkg::CHAR_W-1:0]    character;
  logic                          last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface inv_result_if;
  logic                          valid;
  logic                          ready;
  logic                          name_ok;
  logic [inv_pkg::DLEN_W-1:0]    driver_length;
  logic [inv_pkg::UNIT_W-1:0]    ppa_value;
  logic                          lun_present;
  logic [inv_pkg::UNIT_W-1:0]    lun_value;

  modport source (output valid, output name_ok, output driver_length, output ppa_value,
                  output lun_present, output lun_value, input ready);
  modport sink   (input valid, input name_ok, input driver_length, input ppa_value,
                  input lun_present, input lun_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/interface_name_validator.sv =====
// ----------------------------------------------------------------------------
// Interface name validator
// Streams a name one character per transfer and reports whether it is a
// valid driver/unit[:lun] interface name.
// ----------------------------------------------------------------------------
// Usage:
//   char_i   : one character per transfer; last_char marks the end of a name.
//   result_o : one transfer per name, issued for the character with last_char.
// Path: a final character passes the input register, then the state update
//   and the result register, before result_o.valid rises.
// Throughput: one character per cycle while no final character waits on a
//   pending result (see Stall). The per-character state update is a
//   multiply-by-ten accumulate plus compares in the parser state loop.
// Stall: while a result waits, non-final characters keep flowing; a final
//   character is held in the input register until the result slot frees up,
//   and char_i.ready drops only then.
// Reset: asynchronous, active low; empties both registers and clears the
//   parser state. The state also clears after every name.
// Invalid names report name_ok = 0 with every other field zero.
// ----------------------------------------------------------------------------
`default_nettype none

module interface_name_validator #(
  parameter int unsigned NAME_LIMIT = 32
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  inv_char_if.sink       char_i,
  inv_result_if.source   result_o
);

`include "interface_name_validator_macros.svh"

  localparam int unsigned CNT_W = $clog2(NAME_LIMIT + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(NAME_LIMIT);

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                           s1_valid_q, s1_valid_d;
  logic [inv_pkg::CHAR_W-1:0]     s1_char_q;
  logic                           s1_last_q;
  logic                           in_fire;
  logic                           s1_fire;
  logic                           done_fire;

  // A final character needs the result slot; others only touch state.
  assign s1_fire   = s1_valid_q && (!s1_last_q || !result_o.valid || result_o.ready);
  assign done_fire = s1_fire && s1_last_q;
  assign char_i.ready = !s1_valid_q || s1_fire;
  assign in_fire   = char_i.valid && char_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= char_i.character;
      s1_last_q <= char_i.last_char;
    end
  end

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]               char_count_q, char_count_d;
  logic                           in_lun_q, in_lun_d;
  logic                           drv_bad_q, drv_bad_d;
  logic [inv_pkg::RUN_W-1:0]      name_len_q, name_len_d;
  logic [inv_pkg::RUN_W-1:0]      run_len_q, run_len_d;
  logic                           lead_zero_q, lead_zero_d;
  logic [inv_pkg::UNIT_W-1:0]     unit_acc_q, unit_acc_d;
  logic                           unit_ovf_q, unit_ovf_d;
  logic [inv_pkg::UNIT_W-1:0]     lun_acc_q, lun_acc_d;
  logic                           lun_ovf_q, lun_ovf_d;
  logic                           lun_seen_q, lun_seen_d;
  logic                           lun_bad_q, lun_bad_d;

  logic                           c_digit;
  logic                           c_alpha;
  logic [3:0]                     c_val;
  inv_pkg::acc_step_t             unit_step;
  inv_pkg::acc_step_t             lun_step;

  assign c_digit   = inv_pkg::is_digit(s1_char_q);
  assign c_alpha   = inv_pkg::is_alpha(s1_char_q);
  assign c_val     = s1_char_q[3:0];  // digit value for '0'..'9'
  assign unit_step = inv_pkg::acc_step(unit_acc_q, c_val);
  assign lun_step  = inv_pkg::acc_step(lun_acc_q, c_val);

  // Next state with the current character folded in.
  always_comb begin
    char_count_d = char_count_q;
    in_lun_d     = in_lun_q;
    drv_bad_d    = drv_bad_q;
    name_len_d   = name_len_q;
    run_len_d    = run_len_q;
    lead_zero_d  = lead_zero_q;
    unit_acc_d   = unit_acc_q;
    unit_ovf_d   = unit_ovf_q;
    lun_acc_d    = lun_acc_q;
    lun_ovf_d    = lun_ovf_q;
    lun_seen_d   = lun_seen_q;
    lun_bad_d    = lun_bad_q;

    if (char_count_q < CNT_LIMIT) begin
      char_count_d = char_count_q + 1'b1;
    end

    if (in_lun_q) begin
      // everything after the first colon is the logical unit
      if (c_digit) begin
        lun_acc_d  = lun_step.acc;
        lun_ovf_d  = lun_ovf_q | lun_step.ovf;
        lun_seen_d = 1'b1;
      end else begin
        lun_bad_d = 1'b1;
      end
    end else if (s1_char_q == inv_pkg::CHAR_COLON) begin
      in_lun_d = 1'b1;
    end else begin
      if ((name_len_q == '0) && !c_alpha) begin
        drv_bad_d = 1'b1;
      end
      if (c_digit) begin
        if (run_len_q == '0) begin
          lead_zero_d = (s1_char_q == inv_pkg::CHAR_ZERO);
        end
        if (run_len_q < inv_pkg::RUN_MAX) begin
          run_len_d = run_len_q + 1'b1;
        end
        unit_acc_d = unit_step.acc;
        unit_ovf_d = unit_ovf_q | unit_step.ovf;
      end else begin
        // non-digit ends any digit run: it was part of the driver name
        if (!c_alpha && (s1_char_q != inv_pkg::CHAR_UNDERSCORE) &&
            (s1_char_q != inv_pkg::CHAR_DOT)) begin
          drv_bad_d = 1'b1;
        end
        run_len_d   = '0;
        lead_zero_d = 1'b0;
        unit_acc_d  = '0;
        unit_ovf_d  = 1'b0;
      end
      if (name_len_q < inv_pkg::RUN_MAX) begin
        name_len_d = name_len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
      in_lun_q     <= 1'b0;
      drv_bad_q    <= 1'b0;
      name_len_q   <= '0;
      run_len_q    <= '0;
      lead_zero_q  <= 1'b0;
      unit_acc_q   <= '0;
      unit_ovf_q   <= 1'b0;
      lun_acc_q    <= '0;
      lun_ovf_q    <= 1'b0;
      lun_seen_q   <= 1'b0;
      lun_bad_q    <= 1'b0;
    end else if (done_fire) begin
      // name finished: start the next one clean
      char_count_q <= '0;
      in_lun_q     <= 1'b0;
      drv_bad_q    <= 1'b0;
      name_len_q   <= '0;
      run_len_q    <= '0;
      lead_zero_q  <= 1'b0;
      unit_acc_q   <= '0;
      unit_ovf_q   <= 1'b0;
      lun_acc_q    <= '0;
      lun_ovf_q    <= 1'b0;
      lun_seen_q   <= 1'b0;
      lun_bad_q    <= 1'b0;
    end else if (s1_fire) begin
      char_count_q <= char_count_d;
      in_lun_q     <= in_lun_d;
      drv_bad_q    <= drv_bad_d;
      name_len_q   <= name_len_d;
      run_len_q    <= run_len_d;
      lead_zero_q  <= lead_zero_d;
      unit_acc_q   <= unit_acc_d;
      unit_ovf_q   <= unit_ovf_d;
      lun_acc_q    <= lun_acc_d;
      lun_ovf_q    <= lun_ovf_d;
      lun_seen_q   <= lun_seen_d;
      lun_bad_q    <= lun_bad_d;
    end
  end

  // --------------------------------------------------------------------------
  // Verdict on the updated state
  // --------------------------------------------------------------------------
  logic                           ok;
  logic [inv_pkg::RUN_W-1:0]      drv_len_full;
  logic [inv_pkg::DLEN_W-1:0]     drv_len;

  always_comb begin
    ok = (char_count_d < CNT_LIMIT)
      && (name_len_d != '0)
      && (run_len_d != '0)
      && (run_len_d < name_len_d)
      && !((run_len_d > inv_pkg::RUN_W'(1)) && lead_zero_d)
      && !unit_ovf_d
      && (unit_acc_d <= inv_pkg::UNIT_MAX)
      && !drv_bad_d;
    if (in_lun_d) begin
      ok = ok && lun_seen_d && !lun_bad_d && !lun_ovf_d;
    end
  end

  // run shorter than the name whenever ok, so no underflow matters here
  assign drv_len_full = name_len_d - run_len_d;
  assign drv_len      = (drv_len_full > inv_pkg::RUN_W'(inv_pkg::DLEN_MAX))
                        ? inv_pkg::DLEN_MAX : drv_len_full[inv_pkg::DLEN_W-1:0];

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                           out_valid_q, out_valid_d;
  logic                           name_ok_q;
  logic [inv_pkg::DLEN_W-1:0]     drv_len_q;
  logic [inv_pkg::UNIT_W-1:0]     ppa_q;
  logic                           lun_present_q;
  logic [inv_pkg::UNIT_W-1:0]     lun_value_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (done_fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      name_ok_q     <= ok;
      drv_len_q     <= ok ? drv_len : '0;
      ppa_q         <= ok ? unit_acc_d : '0;
      lun_present_q <= ok && in_lun_d;
      lun_value_q   <= (ok && in_lun_d) ? lun_acc_d : '0;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.name_ok       = name_ok_q;
  assign result_o.driver_length = drv_len_q;
  assign result_o.ppa_value     = ppa_q;
  assign result_o.lun_present   = lun_present_q;
  assign result_o.lun_value     = lun_value_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `INV_ASSERT_IMP(a_bad_name_zero, clk_i, rst_ni, out_valid_q && !name_ok_q, (drv_len_q == '0) && (ppa_q == '0) && !lun_present_q && (lun_value_q == '0))
  `INV_ASSERT_IMP(a_lun_needs_ok, clk_i, rst_ni, out_valid_q && lun_present_q, name_ok_q)
  `INV_ASSERT_IMP(a_unit_in_range, clk_i, rst_ni, out_valid_q && name_ok_q, ppa_q != {inv_pkg::UNIT_W{1'b1}})
  `INV_ASSERT_NXT(a_state_cleared, clk_i, rst_ni, done_fire, (char_count_q == '0) && !in_lun_q && (name_len_q == '0) && out_valid_q)

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Interface name validator testbench
// Streams names one character per transfer into the validator and checks
// every verdict against a cycle-free parser kept in the bench. Directed
// names cover the corner cases, then random well-formed, broken and noise
// names run under four idling phases on both channels.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned NAME_LIMIT      = 32;
  localparam int unsigned CYCLE_LIMIT     = 400000;  // slowest legal run is far below
  localparam int unsigned CHARS_PER_PHASE = 475;     // four random phases
  localparam int unsigned DRAIN_CYCLES    = 8;       // extra wait for stray results
  localparam int unsigned MAX_REPORTS     = 10;

  // One verdict, laid out as the result channel carries it.
  typedef struct packed {
    logic                       ok;
    logic [inv_pkg::DLEN_W-1:0] drv_len;
    logic [inv_pkg::UNIT_W-1:0] unit;
    logic                       lun_given;
    logic [inv_pkg::UNIT_W-1:0] lun;
  } name_verdict_t;

  logic clk_i;
  logic rst_ni;

  inv_char_if   char_bus ();
  inv_result_if result_bus ();

  interface_name_validator #(
    .NAME_LIMIT (NAME_LIMIT)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_bus),
    .result_o (result_bus)
  );

  // --------------------------------------------------------------------------
  // Clock and cycle counter
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Hang guard: a lost transfer or a stuck ready ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** interface_name_validator: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  name_verdict_t              expected_verdicts[$];  // one per final character
  logic [inv_pkg::CHAR_W-1:0] name_buf[$];           // name under construction
  int unsigned                fault_count   = 0;
  int unsigned                send_idle_pct = 0;     // chance per transfer that sender waits
  int unsigned                stall_pct     = 0;     // chance per cycle that ready is low
  logic                       quiet_stretch = 1'b0;  // suspends idling on both sides

  // Parser copy: mirrors the per-name state of the block.
  logic [6:0]                 seen_count;
  logic                       in_lun;
  logic                       driver_bad;
  logic [inv_pkg::RUN_W-1:0]  part_len;
  logic [inv_pkg::RUN_W-1:0]  run_len;
  logic                       run_zero_lead;
  logic [inv_pkg::UNIT_W-1:0] unit_acc;
  logic                       unit_ovf;
  logic [inv_pkg::UNIT_W-1:0] lun_acc;
  logic                       lun_ovf;
  logic                       lun_digit;
  logic                       lun_bad;

  // --------------------------------------------------------------------------
  // Parser copy
  // --------------------------------------------------------------------------
  function automatic logic char_is_digit(input logic [inv_pkg::CHAR_W-1:0] c);
    return (c >= inv_pkg::CHAR_ZERO) && (c <= inv_pkg::CHAR_NINE);
  endfunction

  function automatic logic char_is_letter(input logic [inv_pkg::CHAR_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Decimal shift-in; the top bit flags overflow, the value clamps to all ones.
  function automatic logic [inv_pkg::UNIT_W:0] shift_in_digit(
      input logic [inv_pkg::UNIT_W-1:0] acc,
      input logic [3:0]                 digit);
    logic [inv_pkg::UNIT_W+3:0] wide;
    wide = {4'b0, acc} * 10 + digit;
    if (|wide[inv_pkg::UNIT_W+3:inv_pkg::UNIT_W]) return {1'b1, {inv_pkg::UNIT_W{1'b1}}};
    return {1'b0, wide[inv_pkg::UNIT_W-1:0]};
  endfunction

  task automatic clear_parser();
    seen_count    = '0;
    in_lun        = 1'b0;
    driver_bad    = 1'b0;
    part_len      = '0;
    run_len       = '0;
    run_zero_lead = 1'b0;
    unit_acc      = '0;
    unit_ovf      = 1'b0;
    lun_acc       = '0;
    lun_ovf       = 1'b0;
    lun_digit     = 1'b0;
    lun_bad       = 1'b0;
  endtask

  // Advance the parser by one character; a final character queues a verdict.
  task automatic parse_char(input logic [inv_pkg::CHAR_W-1:0] c, input logic is_final);
    logic [inv_pkg::UNIT_W:0]  stepped;
    logic [inv_pkg::RUN_W-1:0] drv;
    logic                      ok;
    name_verdict_t             v;
    if (seen_count < NAME_LIMIT) seen_count = seen_count + 1;
    if (in_lun) begin
      // everything after the first colon belongs to the logical unit
      if (char_is_digit(c)) begin
        stepped   = shift_in_digit(lun_acc, 4'(c - inv_pkg::CHAR_ZERO));
        lun_acc   = stepped[inv_pkg::UNIT_W-1:0];
        lun_ovf   = lun_ovf | stepped[inv_pkg::UNIT_W];
        lun_digit = 1'b1;
      end else begin
        lun_bad = 1'b1;
      end
    end else if (c == inv_pkg::CHAR_COLON) begin
      in_lun = 1'b1;
    end else begin
      if (part_len == 0 && !char_is_letter(c)) driver_bad = 1'b1;
      if (char_is_digit(c)) begin
        if (run_len == 0) run_zero_lead = (c == inv_pkg::CHAR_ZERO);
        if (run_len < inv_pkg::RUN_MAX) run_len = run_len + 1;
        stepped  = shift_in_digit(unit_acc, 4'(c - inv_pkg::CHAR_ZERO));
        unit_acc = stepped[inv_pkg::UNIT_W-1:0];
        unit_ovf = unit_ovf | stepped[inv_pkg::UNIT_W];
      end else begin
        // a non-digit ends any digit run, so the unit restarts
        if (!char_is_letter(c) && c != inv_pkg::CHAR_UNDERSCORE && c != inv_pkg::CHAR_DOT)
          driver_bad = 1'b1;
        run_len       = '0;
        run_zero_lead = 1'b0;
        unit_acc      = '0;
        unit_ovf      = 1'b0;
      end
      if (part_len < inv_pkg::RUN_MAX) part_len = part_len + 1;
    end

    if (is_final) begin
      ok = (seen_count < NAME_LIMIT) && (part_len != 0) && (run_len != 0)
           && (run_len < part_len) && !(run_len > 1 && run_zero_lead)
           && !unit_ovf && (unit_acc <= inv_pkg::UNIT_MAX) && !driver_bad;
      if (in_lun) ok = ok && lun_digit && !lun_bad && !lun_ovf;
      drv = part_len - ((run_len <= part_len) ? run_len : part_len);
      v.ok        = ok;
      v.drv_len   = !ok ? '0
                  : (drv > inv_pkg::RUN_W'(inv_pkg::DLEN_MAX)) ? inv_pkg::DLEN_MAX
                  : drv[inv_pkg::DLEN_W-1:0];
      v.unit      = ok ? unit_acc : '0;
      v.lun_given = ok && in_lun;
      v.lun       = (ok && in_lun) ? lun_acc : '0;
      expected_verdicts.push_back(v);
      clear_parser();
    end
  endtask

  initial clear_parser();

  // Every accepted character goes through the parser copy. Sampling in the
  // active region of the rising edge sees the values the edge captured.
  always @(posedge clk_i) begin
    if (rst_ni && char_bus.valid && char_bus.ready)
      parse_char(char_bus.character, char_bus.last_char);
  end

  // --------------------------------------------------------------------------
  // Result side: random ready, field-by-field check against the oldest verdict
  // --------------------------------------------------------------------------
  always @(negedge clk_i)
    result_bus.ready <= quiet_stretch || ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin : check_results
    name_verdict_t got;
    name_verdict_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      got.ok        = result_bus.name_ok;
      got.drv_len   = result_bus.driver_length;
      got.unit      = result_bus.ppa_value;
      got.lun_given = result_bus.lun_present;
      got.lun       = result_bus.lun_value;
      if (expected_verdicts.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("[%0d] unexpected result: ok=%0b len=%0d unit=%0d lun_p=%0b lun=%0d",
                   cycle_count, got.ok, got.drv_len, got.unit, got.lun_given, got.lun);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.ok !== want.ok || got.drv_len !== want.drv_len || got.unit !== want.unit
            || got.lun_given !== want.lun_given || got.lun !== want.lun) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display({"[%0d] mismatch: exp ok=%0b len=%0d unit=%0d lun_p=%0b lun=%0d",
                      " | act ok=%0b len=%0d unit=%0d lun_p=%0b lun=%0d"},
                     cycle_count, want.ok, want.drv_len, want.unit, want.lun_given,
                     want.lun, got.ok, got.drv_len, got.unit, got.lun_given, got.lun);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Character side
  // --------------------------------------------------------------------------
  // Entered and left at a falling edge. Each falling edge carries exactly one
  // update of valid, so a back-to-back transfer keeps valid high.
  task automatic send_char(input logic [inv_pkg::CHAR_W-1:0] c, input logic is_final);
    while (!quiet_stretch && $urandom_range(99) < send_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk_i);
      @(negedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.character <= c;
    char_bus.last_char <= is_final;
    do @(posedge clk_i); while (!char_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic send_name();
    for (int i = 0; i < name_buf.size(); i++)
      send_char(name_buf[i], i == name_buf.size() - 1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Name builders
  // --------------------------------------------------------------------------
  function automatic logic [inv_pkg::CHAR_W-1:0] random_letter();
    if ($urandom_range(1)) return 8'h41 + inv_pkg::CHAR_W'($urandom_range(25));
    return 8'h61 + inv_pkg::CHAR_W'($urandom_range(25));
  endfunction

  function automatic logic [inv_pkg::CHAR_W-1:0] random_digit();
    return inv_pkg::CHAR_ZERO + inv_pkg::CHAR_W'($urandom_range(9));
  endfunction

  function automatic logic [inv_pkg::CHAR_W-1:0] random_non_digit();
    logic [inv_pkg::CHAR_W-1:0] b;
    b = inv_pkg::CHAR_W'($urandom_range(1, 255));
    while (char_is_digit(b)) b = inv_pkg::CHAR_W'($urandom_range(1, 255));
    return b;
  endfunction

  // Legal driver character; digits only where they cannot join the unit.
  function automatic logic [inv_pkg::CHAR_W-1:0] random_driver_char(input logic digit_ok);
    case ($urandom_range(digit_ok ? 4 : 3))
      0:       return inv_pkg::CHAR_UNDERSCORE;
      1:       return inv_pkg::CHAR_DOT;
      4:       return random_digit();
      default: return random_letter();
    endcase
  endfunction

  task automatic push_decimal(input logic [63:0] value);
    logic [inv_pkg::CHAR_W-1:0] digs[$];
    do begin
      digs.push_front(inv_pkg::CHAR_ZERO + inv_pkg::CHAR_W'(value % 10));
      value = value / 10;
    end while (value != 0);
    foreach (digs[i]) name_buf.push_back(digs[i]);
  endtask

  task automatic push_random_digits(input int unsigned n);
    repeat (n) name_buf.push_back(random_digit());
  endtask

  // driver + unit + optional logical unit, with the unit and lun drawn
  // around their limits often enough to hit both sides of each bound
  task automatic build_wellformed_name();
    int unsigned drv_chars;
    name_buf.delete();
    drv_chars = ($urandom_range(4) == 0) ? $urandom_range(7, 28) : $urandom_range(1, 6);
    name_buf.push_back(random_letter());
    for (int i = 1; i < drv_chars; i++)
      name_buf.push_back(random_driver_char(i != drv_chars - 1));
    case ($urandom_range(9))
      0:       name_buf.push_back(inv_pkg::CHAR_ZERO);
      1:       push_decimal(64'(inv_pkg::UNIT_MAX));
      2:       push_decimal(64'hFFFF_FFFF);
      3:       push_decimal(64'h1_0000_0000 + $urandom_range(1000));
      4: begin
        name_buf.push_back(inv_pkg::CHAR_ZERO);
        push_random_digits($urandom_range(1, 3));
      end
      5:       push_random_digits($urandom_range(11, 14));
      6:       push_decimal(64'($urandom));
      default: push_decimal(64'($urandom_range(1, 9999)));
    endcase
    if ($urandom_range(9) < 4) begin
      name_buf.push_back(inv_pkg::CHAR_COLON);
      case ($urandom_range(7))
        0: ;                                        // empty logical unit
        1:       push_decimal(64'hFFFF_FFFF);
        2:       push_decimal(64'h1_0000_0000 + $urandom_range(1000));
        3: begin
          push_random_digits(0);
          repeat ($urandom_range(1, 3)) name_buf.push_back(inv_pkg::CHAR_ZERO);
          push_random_digits($urandom_range(0, 4));
        end
        4: begin
          push_random_digits($urandom_range(1, 3));
          name_buf.push_back(random_non_digit());
        end
        5: begin                                    // second colon
          push_random_digits($urandom_range(1, 2));
          name_buf.push_back(inv_pkg::CHAR_COLON);
          push_random_digits($urandom_range(1, 2));
        end
        6:       push_decimal(64'($urandom));
        default: push_decimal(64'($urandom_range(0, 999)));
      endcase
    end
  endtask

  // Letters then one digit, sized around the length limit and beyond the
  // saturation of the part counters.
  task automatic build_boundary_name();
    int unsigned total;
    name_buf.delete();
    case ($urandom_range(4))
      0:       total = NAME_LIMIT - 1;
      1:       total = NAME_LIMIT;
      2:       total = NAME_LIMIT + 1;
      3:       total = 64;
      default: total = 70;
    endcase
    repeat (total - 1) name_buf.push_back(random_letter());
    name_buf.push_back(inv_pkg::CHAR_ZERO + inv_pkg::CHAR_W'($urandom_range(1, 9)));
  endtask

  // A well-formed name with one defect.
  task automatic build_broken_name();
    int unsigned pos;
    build_wellformed_name();
    pos = $urandom_range(name_buf.size() - 1);
    case ($urandom_range(3))
      0: name_buf[pos] = inv_pkg::CHAR_W'($urandom_range(1, 255));
      1: name_buf.delete(pos);
      2: name_buf[pos] = inv_pkg::CHAR_COLON;
      3: name_buf.push_front(random_digit());
    endcase
  endtask

  task automatic build_noise_name();
    name_buf.delete();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(3))
        0: name_buf.push_back(inv_pkg::CHAR_W'($urandom_range(1, 255)));
        1: name_buf.push_back(random_digit());
        2: name_buf.push_back(inv_pkg::CHAR_COLON);
        3: name_buf.push_back(random_letter());
      endcase
    end
  endtask

  task automatic run_random_names(input int unsigned target);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60)      build_wellformed_name();
      else if (pick < 65) build_boundary_name();
      else if (pick < 85) build_broken_name();
      else                build_noise_name();
      quiet_stretch = ($urandom_range(9) == 0);
      send_name();
      sent += name_buf.size();
    end
    quiet_stretch = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_names();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_text("a0");        // lone zero unit is fine
    send_text("b01");       // leading zero unit
    send_text("c7:00");     // logical unit with leading zeros
    send_text("d1:");       // empty logical unit
    send_text("_1");        // driver must start with a letter
    send_text("1");         // digits only, no driver
    send_text(":");         // colon alone
    send_text("f.2");       // dot inside the driver
    send_char(8'h00, 1'b1); // NUL byte as an ordinary bad character
    send_char(8'h61, 1'b0); // high byte inside the driver
    send_char(8'hC1, 1'b0);
    send_char(8'h31, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_streaming_no_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_names(CHARS_PER_PHASE);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 65;
    stall_pct     = 0;
    run_random_names(CHARS_PER_PHASE);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    stall_pct     = 65;
    run_random_names(CHARS_PER_PHASE);
  endtask

  task automatic test_both_sides_idle();
    send_idle_pct = 24;
    stall_pct     = 24;
    run_random_names(CHARS_PER_PHASE);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni              = 1'b0;
    char_bus.valid      = 1'b0;
    char_bus.character  = '0;
    char_bus.last_char  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_names();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    char_bus.valid <= 1'b0;

    // drain, then keep watching for stray results
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0 && expected_verdicts.size() == 0) begin
      $display("** interface_name_validator: PASSED **");
    end else begin
      $display("** interface_name_validator: FAILED **");
    end
    $finish;
  end

endmodule
